/* hdl/aoce_pkg.sv */
package aoce_pkg;

  localparam int TABLE_SLOTS = 32;
  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // 0.26 truncated to Q16.16
  localparam logic [31:0] CLIMB_RESET = 32'd17039;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_SKIP
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_END,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        hx;
    logic [30:0]        hy;
    logic [30:0]        hz;
  } box_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] slot;
    logic             present;
    logic [7:0]       tag;
    box_t             box;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  slot;
    logic        axis;
    logic        neg;
    logic [31:0] depth;
  } contact_t;

  typedef struct packed {
    logic idle;
    logic in_flight;
    logic pend_valid;
  } back_stat_t;

endpackage

/* hdl/aoce_front.sv */
module aoce_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [4:0]          slot,
  input  logic                present,
  input  logic [7:0]          query_tag,
  input  logic signed [31:0]  center_x,
  input  logic signed [31:0]  center_y,
  input  logic signed [31:0]  center_z,
  input  logic [30:0]         half_x,
  input  logic [30:0]         half_y,
  input  logic [30:0]         half_z,
  input  logic                q_full,
  output logic                push,
  output aoce_pkg::cmd_t      push_word
);

  logic           hold_valid;
  logic           take;
  aoce_pkg::cmd_t word_next;

  assign in_stall = hold_valid && q_full;
  assign push     = hold_valid && !q_full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    word_next.slot        = aoce_pkg::IDX_W'(slot);
    word_next.present     = present;
    word_next.tag         = query_tag;
    word_next.box.cx      = center_x;
    word_next.box.cy      = center_y;
    word_next.box.cz      = center_z;
    word_next.box.hx      = half_x;
    word_next.box.hy      = half_y;
    word_next.box.hz      = half_z;
    priority if (cmd) begin
      word_next.op = aoce_pkg::OP_QUERY;
    end else if (int'(slot) < aoce_pkg::TABLE_SLOTS) begin
      word_next.op = aoce_pkg::OP_LOAD;
    end else begin
      word_next.op = aoce_pkg::OP_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      push_word <= word_next;
    end
  end

endmodule

/* hdl/aoce_queue.sv */
module aoce_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  aoce_pkg::cmd_t push_word,
  output logic           q_full,
  input  logic           pop,
  output logic           q_valid,
  output aoce_pkg::cmd_t head
);

  aoce_pkg::cmd_t              store [aoce_pkg::QUEUE_DEPTH];
  logic [aoce_pkg::QPTR_W-1:0] wptr;
  logic [aoce_pkg::QPTR_W-1:0] rptr;
  logic [aoce_pkg::QCNT_W-1:0] count;
  logic                        do_push;
  logic                        do_pop;

  assign q_full  = (count == aoce_pkg::QCNT_W'(aoce_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign head    = store[rptr];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == aoce_pkg::QPTR_W'(aoce_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == aoce_pkg::QPTR_W'(aoce_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wptr] <= push_word;
    end
  end

endmodule

/* hdl/aoce_back.sv */
module aoce_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [31:0]          cfg_data,
  input  logic                 q_valid,
  input  aoce_pkg::cmd_t       head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic [4:0]           passive_slot,
  output logic [7:0]           tag_out,
  output logic                 normal_axis,
  output logic                 normal_negative,
  output logic [31:0]          depth,
  output logic                 last,
  output aoce_pkg::back_stat_t stat
);

  aoce_pkg::box_t                mem [aoce_pkg::TABLE_SLOTS];
  logic [aoce_pkg::TABLE_SLOTS-1:0] slot_valid;
  logic [31:0]                   climb;

  aoce_pkg::state_t              state;
  aoce_pkg::state_t              state_next;
  logic [aoce_pkg::IDX_W-1:0]    idx;
  logic [aoce_pkg::IDX_W-1:0]    idx_next;
  logic                          issue_slot;
  logic                          issue_end;
  logic                          adv;
  logic                          in_flight;
  logic                          do_load;
  logic                          do_query;

  aoce_pkg::box_t                qbox;
  logic [7:0]                    qtag;
  aoce_pkg::box_t                rd_box;

  logic                          s1_tok, s1_end, s1_live;
  logic [aoce_pkg::IDX_W-1:0]    s1_slot;
  logic                          s2_tok, s2_end, s2_live;
  logic [aoce_pkg::IDX_W-1:0]    s2_slot;
  logic [32:0]                   s2_dif [3];
  logic [31:0]                   s2_hsum [3];
  logic                          s3_tok, s3_end, s3_live;
  logic [aoce_pkg::IDX_W-1:0]    s3_slot;
  logic signed [33:0]            s3_pen [3];
  logic [2:0]                    s3_neg;

  logic [31:0]                   pc [3];
  logic [31:0]                   qc [3];
  logic [30:0]                   ph [3];
  logic [30:0]                   qh [3];
  logic [32:0]                   dif_next [3];
  logic [31:0]                   hsum_next [3];
  logic [32:0]                   absd [3];
  logic signed [33:0]            pen_next [3];

  logic                          all_pos;
  logic                          sel_x;
  aoce_pkg::contact_t            new_c;
  aoce_pkg::contact_t            pend;
  logic                          pend_valid;
  aoce_pkg::contact_t            res_c;

  assign adv       = !out_valid || !out_stall;
  assign in_flight = s1_tok || s2_tok || s3_tok;
  assign do_load   = pop && (head.op == aoce_pkg::OP_LOAD);
  assign do_query  = pop && (head.op == aoce_pkg::OP_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      climb <= aoce_pkg::CLIMB_RESET;
    end else if (cfg_write) begin
      climb <= cfg_data;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    idx_next   = idx;
    issue_slot = 1'b0;
    issue_end  = 1'b0;
    pop        = 1'b0;
    if (adv) begin
      unique case (state)
        aoce_pkg::ST_IDLE: begin
          if (q_valid) begin
            pop = 1'b1;
            if (head.op == aoce_pkg::OP_QUERY) begin
              state_next = aoce_pkg::ST_SCAN;
              idx_next   = '0;
            end
          end
        end
        aoce_pkg::ST_SCAN: begin
          issue_slot = 1'b1;
          if (idx == aoce_pkg::IDX_W'(aoce_pkg::TABLE_SLOTS - 1)) begin
            state_next = aoce_pkg::ST_END;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
        aoce_pkg::ST_END: begin
          issue_end  = 1'b1;
          state_next = aoce_pkg::ST_DRAIN;
        end
        aoce_pkg::ST_DRAIN: begin
          if (!in_flight) begin
            state_next = aoce_pkg::ST_IDLE;
          end
        end
        default: state_next = aoce_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aoce_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // table
  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[head.slot] <= head.box;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && issue_slot) begin
      rd_box <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (do_load) begin
      slot_valid[head.slot] <= head.present;
    end
  end

  always_ff @(posedge clk) begin
    if (do_query) begin
      qbox <= head.box;
      qtag <= head.tag;
    end
  end

  // compare pipeline
  assign pc[0] = rd_box.cx;
  assign pc[1] = rd_box.cy;
  assign pc[2] = rd_box.cz;
  assign ph[0] = rd_box.hx;
  assign ph[1] = rd_box.hy;
  assign ph[2] = rd_box.hz;
  assign qc[0] = qbox.cx;
  assign qc[1] = qbox.cy;
  assign qc[2] = qbox.cz;
  assign qh[0] = qbox.hx;
  assign qh[1] = qbox.hy;
  assign qh[2] = qbox.hz;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dif_next[a]  = {pc[a][31], pc[a]} - {qc[a][31], qc[a]};
      hsum_next[a] = {1'b0, ph[a]} + {1'b0, qh[a]};
      absd[a]      = s2_dif[a][32] ? (33'd0 - s2_dif[a]) : s2_dif[a];
      pen_next[a]  = $signed({2'b00, s2_hsum[a]} - {1'b0, absd[a]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tok  <= 1'b0;
      s1_end  <= 1'b0;
      s1_live <= 1'b0;
      s2_tok  <= 1'b0;
      s2_end  <= 1'b0;
      s2_live <= 1'b0;
      s3_tok  <= 1'b0;
      s3_end  <= 1'b0;
      s3_live <= 1'b0;
    end else if (adv) begin
      s1_tok  <= issue_slot || issue_end;
      s1_end  <= issue_end;
      s1_live <= issue_slot && slot_valid[idx];
      s2_tok  <= s1_tok;
      s2_end  <= s1_end;
      s2_live <= s1_live;
      s3_tok  <= s2_tok;
      s3_end  <= s2_end;
      s3_live <= s2_live;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_slot <= idx;
      s2_slot <= s1_slot;
      s3_slot <= s2_slot;
      for (int a = 0; a < 3; a++) begin
        s2_dif[a]  <= dif_next[a];
        s2_hsum[a] <= hsum_next[a];
        s3_pen[a]  <= pen_next[a];
        s3_neg[a]  <= s2_dif[a][32];
      end
    end
  end

  // contact selection
  always_comb begin
    all_pos     = (s3_pen[0] > 0) && (s3_pen[1] > 0) && (s3_pen[2] > 0);
    sel_x       = (s3_pen[0] < s3_pen[1]) && (s3_pen[1] > $signed({2'b00, climb}));
    new_c.slot  = 5'(s3_slot);
    new_c.axis  = !sel_x;
    new_c.neg   = sel_x ? s3_neg[0] : s3_neg[1];
    new_c.depth = sel_x ? s3_pen[0][31:0] : s3_pen[1][31:0];
  end

  // one contact is held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (adv) begin
      if (s3_tok && s3_end) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (s3_tok && s3_live && all_pos) begin
        out_valid  <= pend_valid;
        pend_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s3_tok && s3_end) begin
        hit     <= pend_valid;
        res_c   <= pend_valid ? pend : '0;
        tag_out <= qtag;
        last    <= 1'b1;
      end else if (s3_tok && s3_live && all_pos) begin
        hit     <= 1'b1;
        res_c   <= pend;
        tag_out <= qtag;
        last    <= 1'b0;
        pend    <= new_c;
      end
    end
  end

  assign passive_slot    = res_c.slot;
  assign normal_axis     = res_c.axis;
  assign normal_negative = res_c.neg;
  assign depth           = res_c.depth;

  assign stat.idle       = (state == aoce_pkg::ST_IDLE);
  assign stat.in_flight  = in_flight;
  assign stat.pend_valid = pend_valid;

endmodule

/* hdl/aabb_overlap_contact_engine_core.sv */
// Load word: passes through the input register and the queue, then is written to the table in the back end.
// Query word: occupies the back end through the scan, end and drain states; the table
//   memory read port walks one slot per cycle while the output is not stalled; one
//   contact held back for last; output stall holds the back end.
// Reset (rst, synchronous): clears slot valid bits, queue and control, climb_height
//   to 0.26; table contents stay undefined, no clearing pass.
module aabb_overlap_contact_engine_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [4:0]         slot,
  input  logic               present,
  input  logic [7:0]         query_tag,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        half_x,
  input  logic [30:0]        half_y,
  input  logic [30:0]        half_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic [4:0]         passive_slot,
  output logic [7:0]         tag_out,
  output logic               normal_axis,
  output logic               normal_negative,
  output logic [31:0]        depth,
  output logic               last
);

  logic                 push;
  aoce_pkg::cmd_t       push_word;
  logic                 q_full;
  logic                 q_valid;
  logic                 pop;
  aoce_pkg::cmd_t       head;
  aoce_pkg::back_stat_t stat;

  aoce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .slot      (slot),
    .present   (present),
    .query_tag (query_tag),
    .center_x  (center_x),
    .center_y  (center_y),
    .center_z  (center_z),
    .half_x    (half_x),
    .half_y    (half_y),
    .half_z    (half_z),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  aoce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .q_full    (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  aoce_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .q_valid         (q_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hit             (hit),
    .passive_slot    (passive_slot),
    .tag_out         (tag_out),
    .normal_axis     (normal_axis),
    .normal_negative (normal_negative),
    .depth           (depth),
    .last            (last),
    .stat            (stat)
  );

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    stat.idle |-> !stat.in_flight)
    else $error("compare pipeline busy while sequencer idle");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    stat.idle |-> !stat.pend_valid)
    else $error("held contact left over after query");

  a_nohit_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> last)
    else $error("no-hit word not marked last");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

/* tb/sv/aabb_overlap_contact_engine_core_tb.sv */
module aabb_overlap_contact_engine_core_tb;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  localparam logic [30:0] H1 = 31'h0001_0000;
  localparam logic [30:0] HMAX = 31'h7FFF_FFFF;
  localparam logic [31:0] CMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] CMIN = 32'h8000_0000;

  localparam int DIR_N = 16;
  localparam int PHASES = 4;
  localparam int WORDS_PER_PHASE = 48;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 48;

  typedef struct packed {
    logic           cmd;
    logic [4:0]     slot;
    logic           present;
    logic [7:0]     tag;
    aoce_pkg::box_t box;
  } word_t;

  typedef struct packed {
    logic        hit;
    logic [4:0]  slot;
    logic [7:0]  tag;
    logic        axis;
    logic        neg;
    logic [31:0] depth;
    logic        last;
  } contact_res_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic cmd;
  logic [4:0] slot;
  logic present;
  logic [7:0] query_tag;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0] half_x;
  logic [30:0] half_y;
  logic [30:0] half_z;
  logic out_valid;
  logic out_stall;
  logic hit;
  logic [4:0] passive_slot;
  logic [7:0] tag_out;
  logic normal_axis;
  logic normal_negative;
  logic [31:0] depth;
  logic last;

  // typed-in expectation riding along with the current word
  logic drv_typed;
  contact_res_t drv_res;

  logic tx_random = 1'b1;
  logic rx_random = 1'b1;
  int hold_reqs = 0;
  int hold_done = 0;

  aoce_pkg::box_t box_sh [aoce_pkg::TABLE_SLOTS];
  logic [aoce_pkg::TABLE_SLOTS-1:0] slot_live;
  logic [31:0] climb_sh;
  contact_res_t pending_contacts [$];
  int err_cnt = 0;

  word_t dir_rows [DIR_N];
  logic dir_typed [DIR_N];
  contact_res_t dir_res [DIR_N];
  logic [31:0] climb_plan [PHASES];

  aabb_overlap_contact_engine_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .slot(slot),
    .present(present),
    .query_tag(query_tag),
    .center_x(center_x),
    .center_y(center_y),
    .center_z(center_z),
    .half_x(half_x),
    .half_y(half_y),
    .half_z(half_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .passive_slot(passive_slot),
    .tag_out(tag_out),
    .normal_axis(normal_axis),
    .normal_negative(normal_negative),
    .depth(depth),
    .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic word_t mk_word(input logic c, input logic [4:0] s, input logic p,
                                    input logic [7:0] t, input logic [31:0] cx,
                                    input logic [31:0] cy, input logic [31:0] cz,
                                    input logic [30:0] hx, input logic [30:0] hy,
                                    input logic [30:0] hz);
    word_t w;
    w.cmd = c;
    w.slot = s;
    w.present = p;
    w.tag = t;
    w.box.cx = cx;
    w.box.cy = cy;
    w.box.cz = cz;
    w.box.hx = hx;
    w.box.hy = hy;
    w.box.hz = hz;
    return w;
  endfunction

  function automatic contact_res_t no_contact(input logic [7:0] t);
    contact_res_t r;
    r = '0;
    r.tag = t;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] center_of(input aoce_pkg::box_t b, input int a);
    case (a)
      0: return b.cx;
      1: return b.cy;
      default: return b.cz;
    endcase
  endfunction

  function automatic logic [31:0] half_of(input aoce_pkg::box_t b, input int a);
    case (a)
      0: return {1'b0, b.hx};
      1: return {1'b0, b.hy};
      default: return {1'b0, b.hz};
    endcase
  endfunction

  function automatic logic signed [33:0] sx34(input logic [31:0] v);
    return $signed({{2{v[31]}}, v});
  endfunction

  function automatic logic signed [33:0] zx34(input logic [31:0] v);
    return $signed({2'b00, v});
  endfunction

  // active box against every live slot, ascending index
  task automatic predict_contacts(input aoce_pkg::box_t q, input logic [7:0] t);
    contact_res_t found [aoce_pkg::TABLE_SLOTS];
    logic [aoce_pkg::TABLE_SLOTS-1:0] got;
    logic signed [33:0] dif [3];
    logic signed [33:0] pen [3];
    logic signed [33:0] mag;
    logic ok;
    logic ax;
    int last_j;
    got = '0;
    last_j = -1;
    for (int j = 0; j < aoce_pkg::TABLE_SLOTS; j++) begin
      if (slot_live[j]) begin
        ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
          dif[a] = sx34(center_of(box_sh[j], a)) - sx34(center_of(q, a));
          mag = (dif[a] < 0) ? -dif[a] : dif[a];
          pen[a] = zx34(half_of(q, a)) + zx34(half_of(box_sh[j], a)) - mag;
          if (pen[a] <= 0) ok = 1'b0;
        end
        if (ok) begin
          ax = (pen[0] < pen[1] && pen[1] > zx34(climb_sh)) ? AXIS_X : AXIS_Y;
          found[j].hit = 1'b1;
          found[j].slot = 5'(j);
          found[j].tag = t;
          found[j].axis = ax;
          found[j].neg = (dif[ax] < 0);
          found[j].depth = pen[ax][31:0];
          found[j].last = 1'b0;
          got[j] = 1'b1;
          last_j = j;
        end
      end
    end
    if (last_j < 0) begin
      pending_contacts.push_back(no_contact(t));
    end else begin
      for (int j = 0; j < aoce_pkg::TABLE_SLOTS; j++) begin
        if (got[j]) begin
          found[j].last = (j == last_j);
          pending_contacts.push_back(found[j]);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    contact_res_t want;
    aoce_pkg::box_t b;
    if (rst) begin
      slot_live = '0;
      climb_sh = aoce_pkg::CLIMB_RESET;
    end else begin
      if (cfg_write) climb_sh = cfg_data;
      if (out_valid && !out_stall) begin
        if (pending_contacts.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word, hit %0h slot %0h tag %0h", $time, hit,
                   passive_slot, tag_out);
        end else begin
          want = pending_contacts.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("passive_slot", 32'(want.slot), 32'(passive_slot));
          check_field("tag_out", 32'(want.tag), 32'(tag_out));
          check_field("normal_axis", 32'(want.axis), 32'(normal_axis));
          check_field("normal_negative", 32'(want.neg), 32'(normal_negative));
          check_field("depth", want.depth, depth);
          check_field("last", 32'(want.last), 32'(last));
        end
      end
      if (in_valid && !in_stall) begin
        b.cx = center_x;
        b.cy = center_y;
        b.cz = center_z;
        b.hx = half_x;
        b.hy = half_y;
        b.hz = half_z;
        if (cmd == CMD_LOAD) begin
          box_sh[slot] = b;
          slot_live[slot] = present;
        end else if (drv_typed) begin
          pending_contacts.push_back(drv_res);
        end else begin
          predict_contacts(b, query_tag);
        end
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_reqs) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end
      out_stall <= rx_random && ($urandom_range(99) < 33);
    end
  end

  function automatic word_t rand_word();
    logic [31:0] c [3];
    logic [30:0] h [3];
    logic wide_c;
    logic wide_h;
    wide_c = ($urandom_range(99) < 15);
    wide_h = ($urandom_range(99) < 10);
    for (int a = 0; a < 3; a++) begin
      c[a] = wide_c ? $urandom : ($urandom_range(32'h80000) - 32'h40000);
      h[a] = wide_h ? 31'($urandom) : 31'($urandom_range(32'h30000));
    end
    return mk_word(($urandom_range(99) < 55) ? CMD_QUERY : CMD_LOAD,
                   5'($urandom_range(31)), ($urandom_range(99) < 85), 8'($urandom),
                   c[0], c[1], c[2], h[0], h[1], h[2]);
  endfunction

  task automatic send_word(input word_t w, input logic typed, input contact_res_t r);
    if (tx_random && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd <= w.cmd;
    slot <= w.slot;
    present <= w.present;
    query_tag <= w.tag;
    center_x <= w.box.cx;
    center_y <= w.box.cy;
    center_z <= w.box.cz;
    half_x <= w.box.hx;
    half_y <= w.box.hy;
    half_z <= w.box.hz;
    drv_typed <= typed;
    drv_res <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pause: wait out every expected word, then the back end's own latency
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_contacts.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    contact_res_t r;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    cmd <= CMD_LOAD;
    slot <= '0;
    present <= 1'b0;
    query_tag <= '0;
    center_x <= '0;
    center_y <= '0;
    center_z <= '0;
    half_x <= '0;
    half_y <= '0;
    half_z <= '0;
    drv_typed <= 1'b0;
    drv_res <= '0;

    for (int i = 0; i < DIR_N; i++) begin
      dir_typed[i] = 1'b0;
      dir_res[i] = '0;
    end
    // empty table after reset
    dir_rows[0] = mk_word(CMD_QUERY, 5'd0, 1'b0, 8'hA5, 0, 0, 0, H1, H1, H1);
    dir_typed[0] = 1'b1;
    dir_res[0] = no_contact(8'hA5);
    dir_rows[1] = mk_word(CMD_LOAD, 5'd0, 1'b1, 8'hFF, 0, 0, 0, H1, H1, H1);
    // coincident boxes: y normal, plus sign, full overlap depth
    dir_rows[2] = mk_word(CMD_QUERY, 5'd0, 1'b0, 8'h01, 0, 0, 0, H1, H1, H1);
    dir_typed[2] = 1'b1;
    r = '0;
    r.hit = 1'b1;
    r.tag = 8'h01;
    r.axis = AXIS_Y;
    r.depth = 32'h0002_0000;
    r.last = 1'b1;
    dir_res[2] = r;
    // touching on x only
    dir_rows[3] = mk_word(CMD_QUERY, 5'd0, 1'b0, 8'h02, 32'h0002_0000, 0, 0, H1, H1, H1);
    dir_typed[3] = 1'b1;
    dir_res[3] = no_contact(8'h02);
    dir_rows[4] = mk_word(CMD_LOAD, 5'd31, 1'b1, 8'h00, CMAX, CMAX, CMAX, HMAX, HMAX, HMAX);
    dir_rows[5] = mk_word(CMD_QUERY, 5'd0, 1'b0, 8'h03, CMIN, CMIN, CMIN, HMAX, HMAX, HMAX);
    dir_rows[6] = mk_word(CMD_QUERY, 5'd0, 1'b0, 8'h04, CMAX, CMAX, CMAX, HMAX, HMAX, HMAX);
    dir_rows[7] = mk_word(CMD_LOAD, 5'd5, 1'b1, 8'h00, 32'h0001_8000, 0, 0, H1, H1, H1);
    dir_rows[8] = mk_word(CMD_LOAD, 5'd6, 1'b1, 8'h00, 32'hFFFE_8000, 0, 0, H1, H1, H1);
    dir_rows[9] = mk_word(CMD_LOAD, 5'd7, 1'b1, 8'h00, 32'h0001_F000, 32'h0001_E000, 0,
                          H1, H1, H1);
    dir_rows[10] = mk_word(CMD_QUERY, 5'd0, 1'b0, 8'h05, 0, 0, 0, H1, H1, H1);
    dir_rows[11] = mk_word(CMD_LOAD, 5'd0, 1'b0, 8'h3C, 32'h1234_5678, 32'hFEDC_BA98, 0,
                           31'h5555_5555, 31'h2AAA_AAAA, 0);
    dir_rows[12] = mk_word(CMD_QUERY, 5'd31, 1'b1, 8'h06, 0, 0, 0, H1, H1, H1);
    dir_rows[13] = mk_word(CMD_LOAD, 5'd9, 1'b1, 8'h00, 32'h0000_0100, 32'hFFFF_FF00, 0,
                           0, 0, 0);
    // zero center difference counts as plus
    dir_rows[14] = mk_word(CMD_QUERY, 5'd0, 1'b0, 8'hFF, 32'h0000_0100, 32'hFFFF_FF00, 0,
                           31'h10, 31'h10, 31'h10);
    dir_typed[14] = 1'b1;
    r = '0;
    r.hit = 1'b1;
    r.slot = 5'd9;
    r.tag = 8'hFF;
    r.axis = AXIS_Y;
    r.depth = 32'h10;
    r.last = 1'b1;
    dir_res[14] = r;
    // zero-size boxes never overlap
    dir_rows[15] = mk_word(CMD_QUERY, 5'd0, 1'b0, 8'h00, 32'h0000_0100, 32'hFFFF_FF00, 0,
                           0, 0, 0);
    dir_typed[15] = 1'b1;
    dir_res[15] = no_contact(8'h00);

    climb_plan[0] = 32'h0;
    climb_plan[1] = 32'hFFFF_FFFF;
    climb_plan[2] = $urandom_range(32'h30000);
    climb_plan[3] = $urandom;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) send_word(dir_rows[i], dir_typed[i], dir_res[i]);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      cfg_write <= 1'b1;
      cfg_data <= climb_plan[p];
      @(posedge clk);
      cfg_write <= 1'b0;
      tx_random <= (p != 2);
      rx_random <= (p != 2);
      if (p == 1) hold_reqs <= hold_reqs + 1;
      for (int i = 0; i < WORDS_PER_PHASE; i++) send_word(rand_word(), 1'b0, '0);
      settle();
    end

    if (err_cnt == 0 && pending_contacts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
